@@ rtl/stlp_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and types of the binary stl record parser
package stlp_pkg;

   localparam int HEADER_BYTES   = 80;
   localparam int PREAMBLE_BYTES = 84;
   localparam int RECORD_BYTES   = 50;
   localparam int COORD_START    = 12;
   localparam int COORD_COUNT    = 9;

   localparam int LEN_W    = 38;
   localparam int OFF_W    = 7;
   localparam int WORD_W   = 32;
   localparam int PART_W   = 24;
   localparam int MULT_W   = 14;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OFF_W-1:0] OFF_HDR_COUNT   = OFF_W'(HEADER_BYTES);
   localparam logic [OFF_W-1:0] OFF_COUNT_BYTE  = OFF_W'(PREAMBLE_BYTES - 1);
   localparam logic [OFF_W-1:0] OFF_REC_LAST    = OFF_W'(RECORD_BYTES - 1);
   localparam logic [OFF_W-1:0] OFF_COORD_FIRST = OFF_W'(COORD_START);
   localparam logic [OFF_W-1:0] OFF_COORD_END   = OFF_W'(COORD_START + 4 * COORD_COUNT);
   localparam logic [LEN_W-1:0] LEN_PREAMBLE    = LEN_W'(PREAMBLE_BYTES);
   localparam logic [MULT_W-1:0] RECORD_MULT    = MULT_W'(RECORD_BYTES);
   localparam logic [3:0]       COORD_IDX_MAX   = 4'(COORD_COUNT - 1);

   // register select is paddr bit 3 (one 64-bit register per 8 bytes)
   localparam logic CSR_SEL_FILE_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_RECORDS = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_COORD       = 3'd0,
      ST_DONE        = 3'd1,
      ST_NOT_BINARY  = 3'd2,
      ST_ZERO_FACETS = 3'd3,
      ST_NON_FINITE  = 3'd4,
      ST_MISMATCH    = 3'd5
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] bits;
      logic [3:0]        index;
      logic [WORD_W-1:0] facet;
   } result_type;

endpackage

@@ rtl/stlp_front.sv @@
`timescale 1ns / 1ps
// front end: byte tracking, word assembly and classification into result items
module stlp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        last_byte,
   input  logic [stlp_pkg::LEN_W-1:0]  file_length,
   output logic                        emit,
   output stlp_pkg::result_type        result
);

   stlp_pkg::phase_type phase_ff, phase_in;
   logic [stlp_pkg::OFF_W-1:0]  off_ff, off_in;
   logic [stlp_pkg::PART_W-1:0] partial_ff, partial_in;
   logic [stlp_pkg::LEN_W-1:0]  acc_ff, acc_in;
   logic [stlp_pkg::WORD_W-1:0] counter_ff, counter_in;
   logic [stlp_pkg::WORD_W-1:0] total_ff, total_in;
   logic [stlp_pkg::WORD_W-1:0] last_fac_ff, last_fac_in;

   logic [stlp_pkg::MULT_W-1:0] byte_mult;
   logic [stlp_pkg::LEN_W-1:0]  expect_len;
   logic [stlp_pkg::WORD_W-1:0] word;
   logic [stlp_pkg::OFF_W-1:0]  rel_full;
   logic [5:0]                  rel;
   logic [1:0]                  pos;
   logic in_coord, hdr_pre, len_match, hdr_bad, at_last_facet, rec_end, rec_final;
   logic word_done, non_finite, fire;
   logic restart, enter_records, to_discard;

   assign byte_mult     = stlp_pkg::MULT_W'(data_byte) * stlp_pkg::RECORD_MULT;
   assign expect_len    = acc_ff + {byte_mult, stlp_pkg::PART_W'(0)};
   assign word          = {data_byte, partial_ff};
   assign rel_full      = off_ff - stlp_pkg::OFF_COORD_FIRST;
   assign rel           = rel_full[5:0];
   assign pos           = rel[1:0];
   assign in_coord      = (off_ff >= stlp_pkg::OFF_COORD_FIRST) &&
                          (off_ff < stlp_pkg::OFF_COORD_END);
   assign hdr_pre       = off_ff < stlp_pkg::OFF_COUNT_BYTE;
   assign len_match     = file_length == expect_len;
   assign hdr_bad       = !len_match || (word == '0);
   assign at_last_facet = counter_ff == last_fac_ff;
   assign rec_end       = off_ff == stlp_pkg::OFF_REC_LAST;
   assign rec_final     = rec_end && at_last_facet;
   assign word_done     = in_coord && (pos == 2'd3);
   assign non_finite    = word[30:23] == 8'hFF;

   // file-level decisions for this byte
   always_comb begin
      restart       = 1'b0;
      enter_records = 1'b0;
      to_discard    = 1'b0;
      case (phase_ff)
         stlp_pkg::PH_HEADER: begin
            if (hdr_pre) begin
               restart = last_byte;
            end else if (hdr_bad || last_byte) begin
               restart    = last_byte;
               to_discard = !last_byte;
            end else begin
               enter_records = 1'b1;
            end
         end
         stlp_pkg::PH_RECORDS: begin
            if (last_byte && !rec_final) begin
               restart = 1'b1;
            end else if (word_done && non_finite) begin
               to_discard = 1'b1;
            end else if (rec_final) begin
               restart    = last_byte;
               to_discard = !last_byte;
            end
         end
         default: begin
            restart = last_byte;
         end
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (restart) begin
         phase_in = stlp_pkg::PH_HEADER;
      end else if (to_discard) begin
         phase_in = stlp_pkg::PH_DISCARD;
      end else if (enter_records) begin
         phase_in = stlp_pkg::PH_RECORDS;
      end
   end

   // counters and word assembly
   always_comb begin
      off_in      = off_ff;
      partial_in  = partial_ff;
      acc_in      = acc_ff;
      counter_in  = counter_ff;
      total_in    = total_ff;
      last_fac_in = last_fac_ff;
      if (restart) begin
         off_in      = '0;
         partial_in  = '0;
         acc_in      = stlp_pkg::LEN_PREAMBLE;
         counter_in  = '0;
         total_in    = '0;
         last_fac_in = '0;
      end else begin
         case (phase_ff)
            stlp_pkg::PH_HEADER: begin
               if (hdr_pre) begin
                  off_in = off_ff + 1'b1;
                  if (off_ff >= stlp_pkg::OFF_HDR_COUNT) begin
                     partial_in[{off_ff[1:0], 3'b000} +: 8] = data_byte;
                     acc_in = acc_ff + (stlp_pkg::LEN_W'(byte_mult) << {off_ff[1:0], 3'b000});
                  end
               end else begin
                  partial_in = '0;
                  if (enter_records) begin
                     total_in    = word;
                     last_fac_in = word - 1'b1;
                     counter_in  = '0;
                     off_in      = '0;
                  end
               end
            end
            stlp_pkg::PH_RECORDS: begin
               if (in_coord) begin
                  off_in = off_ff + 1'b1;
                  if (pos != 2'd3) begin
                     partial_in[{pos, 3'b000} +: 8] = data_byte;
                  end else begin
                     partial_in = '0;
                  end
               end else if (rec_end) begin
                  off_in     = '0;
                  counter_in = counter_ff + 1'b1;
               end else begin
                  off_in = off_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result item for this byte
   always_comb begin
      fire   = 1'b0;
      result = '0;
      case (phase_ff)
         stlp_pkg::PH_HEADER: begin
            if (hdr_pre) begin
               if (last_byte) begin
                  fire          = 1'b1;
                  result.status = (file_length < stlp_pkg::LEN_PREAMBLE) ?
                                  stlp_pkg::ST_NOT_BINARY : stlp_pkg::ST_MISMATCH;
               end
            end else if (!len_match) begin
               fire          = 1'b1;
               result.status = stlp_pkg::ST_NOT_BINARY;
            end else if (word == '0) begin
               fire          = 1'b1;
               result.status = stlp_pkg::ST_ZERO_FACETS;
            end else if (last_byte) begin
               fire          = 1'b1;
               result.status = stlp_pkg::ST_MISMATCH;
            end
         end
         stlp_pkg::PH_RECORDS: begin
            if (last_byte && !rec_final) begin
               fire          = 1'b1;
               result.status = stlp_pkg::ST_MISMATCH;
               result.facet  = counter_ff;
            end else if (word_done) begin
               fire          = 1'b1;
               result.status = non_finite ? stlp_pkg::ST_NON_FINITE : stlp_pkg::ST_COORD;
               result.bits   = word;
               result.index  = rel[5:2];
               result.facet  = counter_ff;
            end else if (rec_final) begin
               fire          = 1'b1;
               result.status = last_byte ? stlp_pkg::ST_DONE : stlp_pkg::ST_MISMATCH;
               result.facet  = total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign emit = accept && fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= stlp_pkg::PH_HEADER;
         off_ff      <= '0;
         partial_ff  <= '0;
         acc_ff      <= stlp_pkg::LEN_PREAMBLE;
         counter_ff  <= '0;
         total_ff    <= '0;
         last_fac_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         off_ff      <= off_in;
         partial_ff  <= partial_in;
         acc_ff      <= acc_in;
         counter_ff  <= counter_in;
         total_ff    <= total_in;
         last_fac_ff <= last_fac_in;
      end
   end

endmodule

@@ rtl/stlp_back.sv @@
`timescale 1ns / 1ps
// back end: result queue that holds finished items until they are popped
module stlp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  stlp_pkg::result_type push_item,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output stlp_pkg::result_type head
);

   stlp_pkg::result_type slots_ff [stlp_pkg::QUEUE_DEPTH];
   logic [stlp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stlp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stlp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign full   = count_ff == stlp_pkg::QCNT_W'(stlp_pkg::QUEUE_DEPTH);
   assign empty  = count_ff == '0;
   assign do_pop = pop && !empty;
   assign head   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/binary_stl_record_parser_unit.sv @@
`timescale 1ns / 1ps
// top level of the binary stl record parser
// Takes one file byte per clock while full is low; full rises only when four
// results wait unpopped in the result queue, so with a consumer that pops as
// results appear the block sustains one byte per cycle. Each byte is classified
// in the cycle it is accepted; its result, if any, is queued and reaches the
// rsp_ ports once older results are popped. The user must write the file length
// register (address 0, 64-bit data) only while the block is idle; the block does
// not enforce this. After the final byte it is ready for the next file at once.
module binary_stl_record_parser_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          empty,
   input  logic                          pop,
   output logic [2:0]                    rsp_status,
   output logic [31:0]                   rsp_coordinate_bits,
   output logic [3:0]                    rsp_coordinate_index,
   output logic [31:0]                   rsp_facet_index,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [stlp_pkg::CSR_AW-1:0]   paddr,
   input  logic [stlp_pkg::CSR_DW-1:0]   pwdata,
   output logic [stlp_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   logic [stlp_pkg::LEN_W-1:0] len_ff, len_in;
   logic                       len_wr;
   logic                       accept;
   logic                       emit;
   stlp_pkg::result_type       front_item;
   stlp_pkg::result_type       head;

   assign pready = 1'b1;
   assign len_wr = psel && penable && pwrite && pready &&
                   (paddr[3] == stlp_pkg::CSR_SEL_FILE_LENGTH);
   assign len_in = len_wr ? pwdata[stlp_pkg::LEN_W-1:0] : len_ff;
   assign prdata = (paddr[3] == stlp_pkg::CSR_SEL_FILE_LENGTH) ?
                   stlp_pkg::CSR_DW'(len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   assign accept = push && !full;

   stlp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .file_length (len_ff),
      .emit        (emit),
      .result      (front_item)
   );

   stlp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_item (front_item),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   assign rsp_status           = head.status;
   assign rsp_coordinate_bits  = head.bits;
   assign rsp_coordinate_index = head.index;
   assign rsp_facet_index      = head.facet;

endmodule

@@ rtl/stlp_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the binary stl record parser, bound to the top level
module stlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_coordinate_bits,
   input logic [3:0]  rsp_coordinate_index,
   input logic [31:0] rsp_facet_index
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_status) &&
                            $stable(rsp_coordinate_bits) && $stable(rsp_facet_index)))
      else $error("waiting item changed before pop");

   a_finite: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == stlp_pkg::ST_COORD) |-> (rsp_coordinate_bits[30:23] != 8'hFF))
      else $error("non-finite coordinate reported as coordinate");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != stlp_pkg::ST_COORD && rsp_status != stlp_pkg::ST_NON_FINITE)
      |-> (rsp_coordinate_bits == '0 && rsp_coordinate_index == '0))
      else $error("status item carries coordinate fields");

   a_index: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_coordinate_index <= stlp_pkg::COORD_IDX_MAX))
      else $error("coordinate index out of range");

endmodule

bind binary_stl_record_parser_unit stlp_checker u_stlp_checker (
   .clock                (clock),
   .reset                (reset),
   .empty                (empty),
   .pop                  (pop),
   .rsp_status           (rsp_status),
   .rsp_coordinate_bits  (rsp_coordinate_bits),
   .rsp_coordinate_index (rsp_coordinate_index),
   .rsp_facet_index      (rsp_facet_index)
);
